// ===== rtl/core/cbm_pkg.sv =====
`timescale 1ns / 1ps
// package for the cartridge bank mapper: word types, address windows,
// register indexes and the shared modulo unit interface; no dependencies
package cbm_pkg;

    // address window limits
    localparam logic [15:0] ADDR_RAM_EN_END   = 16'h1FFF;
    localparam logic [15:0] ADDR_BANK0_END    = 16'h3FFF;
    localparam logic [15:0] ADDR_UPPER_END    = 16'h5FFF;
    localparam logic [15:0] ADDR_ROM_END      = 16'h7FFF;
    localparam logic [15:0] ADDR_XRAM_START   = 16'hA000;
    localparam logic [15:0] ADDR_XRAM_END     = 16'hBFFF;

    // register write values
    localparam logic [3:0]  RAM_EN_KEY        = 4'hA;

    // reset values of the count registers
    localparam logic [7:0]  ROM_COUNT_RESET   = 8'd128;
    localparam logic [2:0]  RAM_COUNT_RESET   = 3'd0;

    // operation codes
    localparam logic        OP_WRITE          = 1'b0;
    localparam logic        OP_XLAT           = 1'b1;

    // configuration register indexes
    localparam logic        CFG_ROM_BANK_COUNT = 1'b0;
    localparam logic        CFG_RAM_BANK_COUNT = 1'b1;

    // modulo unit sizes: a bank number is at most 7 bits
    localparam int          MOD_DVD_W         = 7;
    localparam int          MOD_DIV_W         = 8;
    localparam int          MOD_CNT_W         = 3;

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_in_item;

    typedef struct packed {
        logic [20:0] phys_addr;
        logic        target;
        logic        mapped;
        logic        ram_enabled;
    } t_out_item;

    typedef struct packed {
        logic                 start;
        logic [MOD_DVD_W-1:0] dividend;
        logic [MOD_DIV_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [MOD_DVD_W-1:0] rem;
    } t_mod_rsp;

endpackage

// ===== rtl/core/cbm_mod_unit.sv =====
`timescale 1ns / 1ps
// shared bit-serial remainder unit, one dividend bit per cycle
// depends on cbm_pkg
module cbm_mod_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbm_pkg::t_mod_req i_req,
    output cbm_pkg::t_mod_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [cbm_pkg::MOD_CNT_W-1:0] r_cnt;
    logic [cbm_pkg::MOD_DVD_W-1:0] r_dvd;
    logic [cbm_pkg::MOD_DVD_W-1:0] r_rem;
    logic [cbm_pkg::MOD_DIV_W-1:0] r_div;
    logic [cbm_pkg::MOD_DIV_W-1:0] w_shift;
    logic [cbm_pkg::MOD_DIV_W-1:0] w_diff;
    logic [cbm_pkg::MOD_DVD_W-1:0] w_rem;

    // restoring step: bring in the next dividend bit, subtract when it fits
    // a zero divisor always subtracts nothing, so the dividend passes through
    always_comb begin
        w_shift = {r_rem, r_dvd[cbm_pkg::MOD_DVD_W-1]};
        w_diff  = w_shift - r_div;
        if (w_shift >= r_div) begin
            w_rem = w_diff[cbm_pkg::MOD_DVD_W-1:0];
        end else begin
            w_rem = w_shift[cbm_pkg::MOD_DVD_W-1:0];
        end
    end

    // step counter, busy and done flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= cbm_pkg::MOD_CNT_W'(cbm_pkg::MOD_DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[cbm_pkg::MOD_DVD_W-2:0], 1'b0};
            r_rem <= w_rem;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/core/cartridge_bank_mapper_top.sv =====
`timescale 1ns / 1ps
// cartridge bank mapper top level: bank registers, sequencer, output word
// depends on cbm_pkg and cbm_mod_unit
//
// One word at a time: each input word is a register write or an address
// translation and yields exactly one output word. Bank numbers are reduced
// by a shared bit-serial remainder unit. A translation outside the bank-0
// window in banking mode 0 or 1 needs no reduction, and its output word is
// valid in the cycle after accept; a translation of the bank-0 window in
// mode 1 needs one reduction, and a register write needs one, or two when
// it hits the upper bank register with a nonzero RAM bank count. The input
// stalls from accept until the output word is taken. The count registers
// are always ready and must be written only while idle.
module cartridge_bank_mapper_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_valid,
    output logic               o_stall,
    input  cbm_pkg::t_in_item  i_item,
    // output words
    output logic               o_valid,
    input  logic               i_stall,
    output cbm_pkg::t_out_item o_item,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAM,
        S_ROM,
        S_XLAT,
        S_OUT
    } t_state;

    t_state             r_state,  n_state;
    logic [7:0]         r_rom_count;
    logic [2:0]         r_ram_count;
    logic               r_ram_on,     n_ram_on;
    logic [4:0]         r_bank_low,   n_bank_low;
    logic [1:0]         r_bank_high,  n_bank_high;
    logic [1:0]         r_ram_select, n_ram_select;
    logic               r_mode,       n_mode;
    logic [6:0]         r_rom_select, n_rom_select;
    logic [15:0]        r_addr,       n_addr;
    cbm_pkg::t_out_item r_out,        n_out;
    cbm_pkg::t_mod_req  r_mod_req,    n_mod_req;
    cbm_pkg::t_mod_rsp  w_mod_rsp;
    logic               w_accept;

    assign w_accept    = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_item      = r_out;
    assign o_cfg_ready = 1'b1;

    // shared remainder unit
    cbm_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_count <= cbm_pkg::ROM_COUNT_RESET;
            r_ram_count <= cbm_pkg::RAM_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cbm_pkg::CFG_ROM_BANK_COUNT: r_rom_count <= i_cfg_data;
                cbm_pkg::CFG_RAM_BANK_COUNT: r_ram_count <= i_cfg_data[2:0];
                default:                     r_rom_count <= r_rom_count;
            endcase
        end
    end

    // sequencer next state, bank register updates and output word
    always_comb begin
        n_state      = r_state;
        n_ram_on     = r_ram_on;
        n_bank_low   = r_bank_low;
        n_bank_high  = r_bank_high;
        n_ram_select = r_ram_select;
        n_mode       = r_mode;
        n_rom_select = r_rom_select;
        n_addr       = r_addr;
        n_out        = r_out;
        n_mod_req    = '{start: 1'b0, dividend: r_mod_req.dividend,
                         divisor: r_mod_req.divisor};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_addr = i_item.addr;
                    n_out  = '{phys_addr: '0, target: 1'b0, mapped: 1'b0,
                               ram_enabled: r_ram_on};
                    if (i_item.op == cbm_pkg::OP_WRITE) begin
                        // register writes by address window
                        if (i_item.addr <= cbm_pkg::ADDR_RAM_EN_END) begin
                            n_ram_on = (i_item.data[3:0] == cbm_pkg::RAM_EN_KEY);
                        end else if (i_item.addr <= cbm_pkg::ADDR_BANK0_END) begin
                            n_bank_low = (i_item.data[4:0] == 5'd0) ? 5'd1
                                                                    : i_item.data[4:0];
                        end else if (i_item.addr <= cbm_pkg::ADDR_UPPER_END) begin
                            n_bank_high = i_item.data[1:0];
                        end else if (i_item.addr <= cbm_pkg::ADDR_ROM_END) begin
                            n_mode = i_item.data[0];
                        end
                        // ram bank first when it must be reduced, then rom bank
                        if (i_item.addr > cbm_pkg::ADDR_BANK0_END &&
                            i_item.addr <= cbm_pkg::ADDR_UPPER_END &&
                            r_ram_count != 3'd0) begin
                            n_mod_req = '{start: 1'b1,
                                          dividend: {5'd0, i_item.data[1:0]},
                                          divisor: {5'd0, r_ram_count}};
                            n_state   = S_RAM;
                        end else begin
                            n_mod_req = '{start: 1'b1,
                                          dividend: {n_bank_high, n_bank_low},
                                          divisor: r_rom_count};
                            n_state   = S_ROM;
                        end
                    end else begin
                        // translation
                        n_state = S_OUT;
                        if (i_item.addr <= cbm_pkg::ADDR_BANK0_END) begin
                            n_out.mapped = 1'b1;
                            if (r_mode) begin
                                n_mod_req = '{start: 1'b1,
                                              dividend: {r_bank_high, 5'd0},
                                              divisor: r_rom_count};
                                n_state   = S_XLAT;
                            end else begin
                                n_out.phys_addr = {5'd0, i_item.addr};
                            end
                        end else if (i_item.addr <= cbm_pkg::ADDR_ROM_END) begin
                            n_out.mapped    = 1'b1;
                            n_out.phys_addr = {r_rom_select, i_item.addr[13:0]};
                        end else if (i_item.addr >= cbm_pkg::ADDR_XRAM_START &&
                                     i_item.addr <= cbm_pkg::ADDR_XRAM_END) begin
                            n_out.mapped = 1'b1;
                            n_out.target = 1'b1;
                            if (r_mode) begin
                                n_out.phys_addr = {6'd0, r_ram_select, i_item.addr[12:0]};
                            end else begin
                                n_out.phys_addr = {8'd0, i_item.addr[12:0]};
                            end
                        end
                    end
                end
            end
            S_RAM: begin
                if (w_mod_rsp.done) begin
                    n_ram_select = w_mod_rsp.rem[1:0];
                    n_mod_req    = '{start: 1'b1,
                                     dividend: {r_bank_high, r_bank_low},
                                     divisor: r_rom_count};
                    n_state      = S_ROM;
                end
            end
            S_ROM: begin
                if (w_mod_rsp.done) begin
                    n_rom_select      = w_mod_rsp.rem;
                    n_out.ram_enabled = r_ram_on;
                    n_state           = S_OUT;
                end
            end
            S_XLAT: begin
                if (w_mod_rsp.done) begin
                    n_out.phys_addr = {w_mod_rsp.rem, r_addr[13:0]};
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, bank registers and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_ram_on        <= 1'b0;
            r_bank_low      <= 5'd1;
            r_bank_high     <= 2'd0;
            r_ram_select    <= 2'd0;
            r_mode          <= 1'b0;
            r_rom_select    <= 7'd1;
            r_mod_req.start <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_ram_on        <= n_ram_on;
            r_bank_low      <= n_bank_low;
            r_bank_high     <= n_bank_high;
            r_ram_select    <= n_ram_select;
            r_mode          <= n_mode;
            r_rom_select    <= n_rom_select;
            r_mod_req.start <= n_mod_req.start;
        end
        r_addr               <= n_addr;
        r_out                <= n_out;
        r_mod_req.dividend   <= n_mod_req.dividend;
        r_mod_req.divisor    <= n_mod_req.divisor;
    end

    // the remainder unit only finishes while the sequencer waits on it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_rsp.done |-> (r_state == S_RAM || r_state == S_ROM || r_state == S_XLAT))
        else $error("remainder done outside a wait state");

    // no output word while the remainder unit is still running
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !w_mod_rsp.busy)
        else $error("output valid with remainder unit busy");

    // the low rom bank never holds zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bank_low != 5'd0)
        else $error("low rom bank is zero");

    // a start is only issued when the unit is free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod_req.start |-> !w_mod_rsp.busy)
        else $error("remainder start while busy");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for cartridge_bank_mapper_top: directed and random bus words checked
// against a bank-state predictor; depends on cbm_pkg and the mapper rtl
module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    cbm_pkg::t_in_item  i_item      = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    cbm_pkg::t_out_item o_item;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = 1'b0;
    logic [7:0]         i_cfg_data  = 8'd0;

    // predicted bank state and count registers
    logic       m_ram_on;
    logic [4:0] m_bank_low;
    logic [1:0] m_bank_high;
    logic [1:0] m_ram_bank;
    logic       m_mode;
    logic [6:0] m_rom_bank;
    logic [7:0] m_rom_count;
    logic [2:0] m_ram_count;

    cbm_pkg::t_out_item pending_words[$];
    cbm_pkg::t_out_item oldest_word;
    int         mismatches    = 0;
    int         cycle_count   = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_request  = 0;
    int         hold_left     = 0;

    cartridge_bank_mapper_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // reduce a bank number by the rom bank count, zero count means no wrap
    function automatic logic [6:0] wrap_rom(input logic [6:0] bank);
        if (m_rom_count == 8'd0)
            return bank;
        return 7'(int'(bank) % int'(m_rom_count));
    endfunction

    // apply one bus word to the predicted state and return the expected word
    function automatic cbm_pkg::t_out_item map_access(input cbm_pkg::t_in_item w);
        cbm_pkg::t_out_item r;
        r = '0;
        if (w.op == cbm_pkg::OP_WRITE) begin
            if (w.addr <= cbm_pkg::ADDR_RAM_EN_END) begin
                m_ram_on = (w.data[3:0] == cbm_pkg::RAM_EN_KEY);
            end else if (w.addr <= cbm_pkg::ADDR_BANK0_END) begin
                m_bank_low = (w.data[4:0] == 5'd0) ? 5'd1 : w.data[4:0];
            end else if (w.addr <= cbm_pkg::ADDR_UPPER_END) begin
                if (m_ram_count != 3'd0)
                    m_ram_bank = 2'(int'(w.data[1:0]) % int'(m_ram_count));
                m_bank_high = w.data[1:0];
            end else if (w.addr <= cbm_pkg::ADDR_ROM_END) begin
                m_mode = w.data[0];
            end
            // effective rom bank is refreshed on every write, mapped or not
            m_rom_bank = wrap_rom({m_bank_high, m_bank_low});
        end else begin
            if (w.addr <= cbm_pkg::ADDR_BANK0_END) begin
                r.mapped = 1'b1;
                if (!m_mode)
                    r.phys_addr = 21'(w.addr);
                else
                    r.phys_addr = {wrap_rom({m_bank_high, 5'd0}), w.addr[13:0]};
            end else if (w.addr <= cbm_pkg::ADDR_ROM_END) begin
                r.mapped    = 1'b1;
                r.phys_addr = {m_rom_bank, w.addr[13:0]};
            end else if (w.addr >= cbm_pkg::ADDR_XRAM_START &&
                         w.addr <= cbm_pkg::ADDR_XRAM_END) begin
                r.mapped = 1'b1;
                r.target = 1'b1;
                if (!m_mode)
                    r.phys_addr = 21'(w.addr - cbm_pkg::ADDR_XRAM_START);
                else
                    r.phys_addr = {6'd0, m_ram_bank, w.addr[12:0]};
            end
        end
        r.ram_enabled = m_ram_on;
        return r;
    endfunction

    function automatic cbm_pkg::t_in_item make_word(input logic op,
                                                    input logic [15:0] addr,
                                                    input logic [7:0] data);
        cbm_pkg::t_in_item w;
        w.op   = op;
        w.addr = addr;
        w.data = data;
        return w;
    endfunction

    // mostly writes and translations aimed at the windows, some fully random
    function automatic cbm_pkg::t_in_item random_word();
        cbm_pkg::t_in_item w;
        int                sel;
        w.data = 8'($urandom_range(0, 255));
        sel    = $urandom_range(0, 99);
        if (sel < 45) begin
            w.op = cbm_pkg::OP_WRITE;
            case ($urandom_range(0, 9))
                0, 1: begin
                    w.addr = 16'($urandom_range(0, 16'h1FFF));
                    if ($urandom_range(0, 1))
                        w.data[3:0] = cbm_pkg::RAM_EN_KEY;
                end
                2, 3, 4: w.addr = 16'($urandom_range(16'h2000, 16'h3FFF));
                5, 6, 7: w.addr = 16'($urandom_range(16'h4000, 16'h5FFF));
                8:       w.addr = 16'($urandom_range(16'h6000, 16'h7FFF));
                default: w.addr = 16'($urandom_range(16'h8000, 16'hFFFF));
            endcase
        end else if (sel < 92) begin
            w.op = cbm_pkg::OP_XLAT;
            case ($urandom_range(0, 6))
                0, 1:    w.addr = 16'($urandom_range(0, 16'h3FFF));
                2, 3:    w.addr = 16'($urandom_range(16'h4000, 16'h7FFF));
                4, 5:    w.addr = 16'($urandom_range(16'hA000, 16'hBFFF));
                default: w.addr = 16'($urandom_range(0, 16'hFFFF));
            endcase
        end else begin
            w.op   = 1'($urandom_range(0, 1));
            w.addr = 16'($urandom_range(0, 16'hFFFF));
        end
        return w;
    endfunction

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_words.size() == 0) begin
                if (mismatches < 10)
                    $display("word with nothing pending: phys=%h tgt=%b map=%b ram=%b",
                             o_item.phys_addr, o_item.target, o_item.mapped,
                             o_item.ram_enabled);
                mismatches = mismatches + 1;
            end else begin
                oldest_word = pending_words.pop_front();
                if (o_item.phys_addr !== oldest_word.phys_addr ||
                    o_item.target !== oldest_word.target ||
                    o_item.mapped !== oldest_word.mapped ||
                    o_item.ram_enabled !== oldest_word.ram_enabled) begin
                    if (mismatches < 10)
                        $display({"mismatch: exp phys=%h tgt=%b map=%b ram=%b, ",
                                  "got phys=%h tgt=%b map=%b ram=%b"},
                                 oldest_word.phys_addr, oldest_word.target,
                                 oldest_word.mapped, oldest_word.ram_enabled,
                                 o_item.phys_addr, o_item.target, o_item.mapped,
                                 o_item.ram_enabled);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // offer one word, leave valid high after accept for a back-to-back word
    task automatic send_word(input cbm_pkg::t_in_item w);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= w;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_words.push_back(map_access(w));
    endtask

    // stop offering and wait for every expected word
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == cbm_pkg::CFG_ROM_BANK_COUNT)
            m_rom_count = value;
        else
            m_ram_count = value[2:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // counts are only changed with the mapper idle
    task automatic set_counts(input logic [7:0] rom_cnt, input logic [2:0] ram_cnt);
        drain;
        write_reg(cbm_pkg::CFG_ROM_BANK_COUNT, rom_cnt);
        write_reg(cbm_pkg::CFG_RAM_BANK_COUNT, {5'd0, ram_cnt});
    endtask

    // every window edge with the reset bank state
    task automatic test_reset_windows;
        send_word(make_word(cbm_pkg::OP_XLAT, 16'h0000, 8'h00));
        send_word(make_word(cbm_pkg::OP_XLAT, 16'h3FFF, 8'hFF));
        send_word(make_word(cbm_pkg::OP_XLAT, 16'h4000, 8'h00));
        send_word(make_word(cbm_pkg::OP_XLAT, 16'h7FFF, 8'hFF));
        send_word(make_word(cbm_pkg::OP_XLAT, 16'h8000, 8'h00));
        send_word(make_word(cbm_pkg::OP_XLAT, 16'h9FFF, 8'hFF));
        send_word(make_word(cbm_pkg::OP_XLAT, 16'hA000, 8'h00));
        send_word(make_word(cbm_pkg::OP_XLAT, 16'hBFFF, 8'hFF));
        send_word(make_word(cbm_pkg::OP_XLAT, 16'hC000, 8'h00));
        send_word(make_word(cbm_pkg::OP_XLAT, 16'hFFFF, 8'hFF));
    endtask

    // each bank register, zero low bank, writes above the register space, mode 1
    task automatic test_register_writes;
        send_word(make_word(cbm_pkg::OP_WRITE, 16'h0000, 8'h0A));
        send_word(make_word(cbm_pkg::OP_WRITE, 16'h1FFF, 8'hF5));
        send_word(make_word(cbm_pkg::OP_WRITE, 16'h1000, 8'hFA));
        send_word(make_word(cbm_pkg::OP_WRITE, 16'h2000, 8'h00));
        send_word(make_word(cbm_pkg::OP_WRITE, 16'h3FFF, 8'hFF));
        send_word(make_word(cbm_pkg::OP_WRITE, 16'h4000, 8'hFF));
        send_word(make_word(cbm_pkg::OP_XLAT,  16'h5ABC, 8'h00));
        send_word(make_word(cbm_pkg::OP_WRITE, 16'h6000, 8'h01));
        send_word(make_word(cbm_pkg::OP_XLAT,  16'h0123, 8'hFF));
        send_word(make_word(cbm_pkg::OP_XLAT,  16'hA555, 8'h00));
        send_word(make_word(cbm_pkg::OP_WRITE, 16'h8000, 8'hFF));
        send_word(make_word(cbm_pkg::OP_WRITE, 16'hFFFF, 8'h00));
        send_word(make_word(cbm_pkg::OP_WRITE, 16'h7FFF, 8'hFE));
        send_word(make_word(cbm_pkg::OP_XLAT,  16'hBFFF, 8'hAA));
        send_word(make_word(cbm_pkg::OP_WRITE, 16'h5FFF, 8'h00));
    endtask

    // count extremes; first word after a change reads the stale rom bank
    task automatic test_count_settings;
        logic [7:0] rom_set[6];
        logic [2:0] ram_set[6];
        rom_set = '{8'd0, 8'd1, 8'd128, 8'd3, 8'd16, 8'd77};
        ram_set = '{3'd4, 3'd1, 3'd4, 3'd3, 3'd0, 3'd2};
        for (int k = 0; k < 6; k++) begin
            set_counts(rom_set[k], ram_set[k]);
            send_word(make_word(cbm_pkg::OP_XLAT,
                                16'($urandom_range(16'h4000, 16'h7FFF)),
                                8'($urandom_range(0, 255))));
            send_word(make_word(cbm_pkg::OP_WRITE, 16'h4000,
                                8'($urandom_range(0, 255))));
            send_word(make_word(cbm_pkg::OP_WRITE, 16'h6000, 8'h01));
            send_word(make_word(cbm_pkg::OP_XLAT,
                                16'($urandom_range(0, 16'h3FFF)), 8'h00));
            send_word(make_word(cbm_pkg::OP_XLAT,
                                16'($urandom_range(16'hA000, 16'hBFFF)), 8'h00));
            for (int j = 0; j < 15; j++)
                send_word(random_word());
        end
    endtask

    // random words, counts changed every hundred words
    task automatic test_random_traffic(input int count);
        logic [7:0] rom_cnt;
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 99) begin
                case ($urandom_range(0, 9))
                    0:       rom_cnt = 8'd0;
                    1:       rom_cnt = 8'd1;
                    2:       rom_cnt = 8'd128;
                    default: rom_cnt = 8'($urandom_range(1, 128));
                endcase
                set_counts(rom_cnt, 3'($urandom_range(0, 4)));
            end
            send_word(random_word());
        end
    endtask

    // long receiver hold-off with the sender still offering, then a full pause
    task automatic test_backpressure;
        drain;
        hold_request = 300;
        for (int k = 0; k < 16; k++)
            send_word(random_word());
        drain;
        for (int k = 0; k < 8; k++)
            send_word(random_word());
        drain;
    endtask

    initial begin
        m_ram_on    = 1'b0;
        m_bank_low  = 5'd1;
        m_bank_high = 2'd0;
        m_ram_bank  = 2'd0;
        m_mode      = 1'b0;
        m_rom_bank  = 7'd1;
        m_rom_count = cbm_pkg::ROM_COUNT_RESET;
        m_ram_count = cbm_pkg::RAM_COUNT_RESET;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 16;
        recv_idle_pct = 85;
        test_reset_windows;
        test_register_writes;
        test_count_settings;
        test_random_traffic(300);

        send_idle_pct = 85;
        recv_idle_pct = 16;
        test_random_traffic(300);
        test_backpressure;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(300);
        test_backpressure;

        drain;
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cbm_pkg.sv
rtl/core/cbm_mod_unit.sv
rtl/core/cartridge_bank_mapper_top.sv
tb/tb_top.sv
